[sv/lkde_pkg.sv]
// types, codes and the key map shared by the keypad digit entry block
// no dependencies

package lkde_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;
   localparam int EDGE_W     = 10;
   localparam int LEN_W      = 4;
   localparam int KEY_W      = 7;
   localparam int PACK_SLOTS = 8;

   localparam logic [1:0] OP_SCAN  = 2'd0;
   localparam logic [1:0] OP_POLL  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW1_EDGE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW2_EDGE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW3_EDGE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW4_EDGE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEN   = 3'd4;

   localparam logic [EDGE_W-1:0] ROW1_RESET    = 10'd900;
   localparam logic [EDGE_W-1:0] ROW2_RESET    = 10'd700;
   localparam logic [EDGE_W-1:0] ROW3_RESET    = 10'd500;
   localparam logic [EDGE_W-1:0] ROW4_RESET    = 10'd300;
   localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 4'd8;

   localparam logic [3:0] BLANK_DIGIT = 4'hf;

   localparam logic [KEY_W-1:0] KEY_NONE = 7'h00;
   localparam logic [KEY_W-1:0] KEY_STAR = 7'h2a;
   localparam logic [KEY_W-1:0] KEY_HASH = 7'h23;
   localparam logic [KEY_W-1:0] KEY_ZERO = 7'h30;
   localparam logic [KEY_W-1:0] KEY_A    = 7'h41;
   localparam logic [KEY_W-1:0] KEY_B    = 7'h42;
   localparam logic [KEY_W-1:0] KEY_C    = 7'h43;
   localparam logic [KEY_W-1:0] KEY_D    = 7'h44;

   typedef struct packed {
      logic [1:0] op;
      logic [2:0] scan_column;
      logic [9:0] adc_sample;
   } req_type;

   typedef struct packed {
      logic [6:0]        key_code;
      logic [6:0]        returned_key;
      logic [31:0]       digits_packed;
      logic signed [3:0] entry_position;
   } rsp_type;

   typedef struct packed {
      logic             poll;
      logic             clear;
      logic [KEY_W-1:0] key;
   } entry_cmd_type;

   // column and row are 1..4, zero means no key
   function automatic logic [KEY_W-1:0] key_lookup(input logic [2:0] col,
                                                   input logic [2:0] row);
      logic [KEY_W-1:0] k;
      k = KEY_NONE;
      if (col inside {[3'd1:3'd4]} && row inside {[3'd1:3'd4]}) begin
         case ({row[1:0] - 2'd1, col[1:0] - 2'd1})
            4'h0: k = 7'h31;
            4'h1: k = 7'h32;
            4'h2: k = 7'h33;
            4'h3: k = KEY_A;
            4'h4: k = 7'h34;
            4'h5: k = 7'h35;
            4'h6: k = 7'h36;
            4'h7: k = KEY_B;
            4'h8: k = 7'h37;
            4'h9: k = 7'h38;
            4'ha: k = 7'h39;
            4'hb: k = KEY_C;
            4'hc: k = KEY_STAR;
            4'hd: k = KEY_ZERO;
            4'he: k = KEY_HASH;
            default: k = KEY_D;
         endcase
      end
      return k;
   endfunction

endpackage

[sv/lkde_entry.sv]
// digit entry store: edit window, write slot and previous key, with next-state logic
// depends on lkde_pkg

module lkde_entry #(
   parameter int DIGITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lkde_pkg::entry_cmd_type       cmd,
   input  logic [lkde_pkg::LEN_W-1:0]    max_len,
   output logic [DIGITS-1:0][3:0]        nxt_digits,
   output logic signed [$clog2(DIGITS):0] nxt_slot,
   output logic [lkde_pkg::KEY_W-1:0]    ret_key
);
   import lkde_pkg::*;

   localparam int SLOT_W = $clog2(DIGITS) + 1;
   localparam logic signed [SLOT_W-1:0] SLOT_TOP  = SLOT_W'(DIGITS - 1);
   localparam logic signed [SLOT_W-1:0] SLOT_NEAR = SLOT_W'(DIGITS - 2);
   localparam logic [4:0] DIGITS_5 = 5'(DIGITS);

   logic [DIGITS-1:0][3:0]    digits_ff, digits_in;
   logic signed [SLOT_W-1:0]  slot_ff, slot_in;
   logic [KEY_W-1:0]          prev_ff, prev_in;
   logic [DIGITS-1:0][3:0]    del_shift, ins_shift;
   logic [4:0]                len_c, lo;
   logic [KEY_W-1:0]          ck;
   logic [KEY_W-1:0]          ret;

   always_comb begin
      if (max_len == '0) begin
         len_c = 5'd1;
      end else if ({1'b0, max_len} > DIGITS_5) begin
         len_c = DIGITS_5;
      end else begin
         len_c = {1'b0, max_len};
      end
      lo = DIGITS_5 - len_c;
   end

   // window shifts right for delete, left for insert
   always_comb begin
      for (int k = 0; k < DIGITS; k++) begin
         del_shift[k] = digits_ff[k];
         ins_shift[k] = digits_ff[k];
         if (5'(k) == lo) begin
            del_shift[k] = BLANK_DIGIT;
         end else if (5'(k) > lo) begin
            del_shift[k] = digits_ff[k-1];
         end
         if (k < DIGITS - 1 && 5'(k) >= lo) begin
            ins_shift[k] = digits_ff[k+1];
         end
      end
   end

   always_comb begin
      digits_in = digits_ff;
      slot_in   = slot_ff;
      prev_in   = prev_ff;
      ret       = KEY_NONE;
      ck        = cmd.key;
      if (cmd.clear) begin
         for (int k = 0; k < DIGITS; k++) begin
            digits_in[k] = BLANK_DIGIT;
         end
         digits_in[DIGITS-1] = 4'h0;
         slot_in = SLOT_TOP;
         prev_in = KEY_NONE;
      end else if (cmd.poll) begin
         if (ck == KEY_NONE) begin
            prev_in = KEY_NONE;
         end else if (ck inside {KEY_A, KEY_B, KEY_C, KEY_D, KEY_HASH}) begin
            prev_in = ck;
            ret     = ck;
         end else if (ck != prev_ff) begin
            prev_in = ck;
            if (ck == KEY_STAR) begin
               if (slot_ff >= SLOT_NEAR) begin
                  slot_in = SLOT_TOP;
                  digits_in[DIGITS-1] = 4'h0;
               end else begin
                  digits_in = del_shift;
                  slot_in   = slot_ff + SLOT_W'(1);
               end
            end else if (!slot_ff[SLOT_W-1]) begin
               if (!(ck == KEY_ZERO && slot_ff == SLOT_TOP)) begin
                  if (slot_ff < SLOT_TOP) begin
                     digits_in = ins_shift;
                  end
                  digits_in[DIGITS-1] = ck[3:0];
                  slot_in = slot_ff - SLOT_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIGITS; k++) begin
            digits_ff[k] <= BLANK_DIGIT;
         end
         digits_ff[DIGITS-1] <= 4'h0;
         slot_ff <= SLOT_TOP;
         prev_ff <= KEY_NONE;
      end else if (cmd.poll || cmd.clear) begin
         digits_ff <= digits_in;
         slot_ff   <= slot_in;
         prev_ff   <= prev_in;
      end
   end

   assign nxt_digits = digits_in;
   assign nxt_slot   = slot_in;
   assign ret_key    = ret;

endmodule

[sv/ladder_keypad_digit_entry_top.sv]
// top level of the ladder keypad digit entry: input register, key latch, result register
// depends on lkde_pkg and lkde_entry
//
//   port group   dir   payload     handshake
//   req_         in    req_type    req_valid / req_stall
//   rsp_         out   rsp_type    rsp_valid / rsp_stall
//   csr_         in    10 bits     csr_write, no wait
//
// one word per cycle sustained while rsp_stall is low; an accepted word is registered in the input register and
// then moves into the result register, whose output drives rsp_valid
// the whole edit is one pass of compares and a parallel digit shift
// synchronous reset sets thresholds, the length limit, the held key and a blank entry
// a stalled result holds and the input register keeps its word until it can move

module ladder_keypad_digit_entry_top #(
   parameter int DIGITS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  lkde_pkg::req_type                req_word,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output lkde_pkg::rsp_type                rsp_word,
   input  logic                             csr_write,
   input  logic [lkde_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lkde_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lkde_pkg::*;

   localparam int SLOT_W = $clog2(DIGITS) + 1;

   logic                 in_valid_ff, in_valid_in;
   req_type              in_word_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_word_ff, rsp_word_in;
   logic [EDGE_W-1:0]    row1_ff, row2_ff, row3_ff, row4_ff;
   logic [LEN_W-1:0]     max_len_ff;
   logic [2:0]           held_col_ff, held_col_in;
   logic [2:0]           held_row_ff, held_row_in;
   logic                 load, advance;
   logic [2:0]           row_hit;
   logic [2:0]           col_id;
   logic [KEY_W-1:0]     key_after;
   entry_cmd_type        cmd;
   logic [DIGITS-1:0][3:0]   nxt_digits;
   logic signed [SLOT_W-1:0] nxt_slot;
   logic signed [SLOT_W+3:0] slot_ext;
   logic [KEY_W-1:0]     ret_key;
   logic [31:0]          packed_digits;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign load      = req_valid && !req_stall;
   assign in_valid_in  = load || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row1_ff    <= ROW1_RESET;
         row2_ff    <= ROW2_RESET;
         row3_ff    <= ROW3_RESET;
         row4_ff    <= ROW4_RESET;
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ROW1_EDGE: row1_ff    <= csr_wdata;
            CSR_ROW2_EDGE: row2_ff    <= csr_wdata;
            CSR_ROW3_EDGE: row3_ff    <= csr_wdata;
            CSR_ROW4_EDGE: row4_ff    <= csr_wdata;
            CSR_MAX_LEN:   max_len_ff <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // ladder classification, zero means no key in this column
   always_comb begin
      if (in_word_ff.adc_sample < row4_ff) begin
         row_hit = 3'd0;
      end else if (in_word_ff.adc_sample > row1_ff) begin
         row_hit = 3'd1;
      end else if (in_word_ff.adc_sample > row2_ff) begin
         row_hit = 3'd2;
      end else if (in_word_ff.adc_sample > row3_ff) begin
         row_hit = 3'd3;
      end else begin
         row_hit = 3'd4;
      end
   end

   always_comb begin
      col_id      = {1'b0, in_word_ff.scan_column[1:0]} + 3'd1;
      held_col_in = held_col_ff;
      held_row_in = held_row_ff;
      if (in_word_ff.op == OP_SCAN && !in_word_ff.scan_column[2]) begin
         if (row_hit != 3'd0) begin
            held_col_in = col_id;
            held_row_in = row_hit;
         end else if (held_col_ff == col_id) begin
            held_col_in = 3'd0;
            held_row_in = 3'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_col_ff <= 3'd0;
         held_row_ff <= 3'd0;
      end else if (advance) begin
         held_col_ff <= held_col_in;
         held_row_ff <= held_row_in;
      end
   end

   assign key_after = key_lookup(held_col_in, held_row_in);

   always_comb begin
      cmd.poll  = advance && in_word_ff.op == OP_POLL;
      cmd.clear = advance && in_word_ff.op == OP_CLEAR;
      cmd.key   = key_after;
   end

   lkde_entry #(
      .DIGITS (DIGITS)
   ) u_entry (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .max_len    (max_len_ff),
      .nxt_digits (nxt_digits),
      .nxt_slot   (nxt_slot),
      .ret_key    (ret_key)
   );

   // rightmost slot in the low nibble, missing slots blank
   for (genvar k = 0; k < PACK_SLOTS; k++) begin : g_pack
      if (k < DIGITS) begin : g_slot
         assign packed_digits[4*k +: 4] = nxt_digits[DIGITS-1-k];
      end else begin : g_blank
         assign packed_digits[4*k +: 4] = BLANK_DIGIT;
      end
   end

   assign slot_ext = (SLOT_W + 4)'(nxt_slot);

   always_comb begin
      rsp_word_in.key_code       = key_after;
      rsp_word_in.returned_key   = ret_key;
      rsp_word_in.digits_packed  = packed_digits;
      rsp_word_in.entry_position = slot_ext[3:0];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[tb/sv/ladder_keypad_digit_entry_top_tb.sv]
// self-checking testbench for the ladder keypad digit entry block: scan, poll, clear and unused-op
// words against a cycle-free predictor of the key latch and the digit entry
// depends on lkde_pkg and ladder_keypad_digit_entry_top

module ladder_keypad_digit_entry_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lkde_pkg::*;

   localparam int NDIG        = 8;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 152;
   localparam int LONG_HOLD   = 120;
   localparam int CYCLE_LIMIT = 500000;
   localparam int DIR_ROWS    = 27;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   // row-major keypad layout, rows top to bottom
   localparam logic [7:0] KEY_MAP [16] = '{"1", "2", "3", "A", "4", "5", "6", "B",
                                          "7", "8", "9", "C", "*", "0", "#", "D"};
   localparam int DIGIT_KEYS [10] = '{0, 1, 2, 4, 5, 6, 8, 9, 10, 13};

   typedef struct packed {
      req_type w;
      logic    known;
      rsp_type rsp;
   } stim_row_type;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_word  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_word;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state
   logic [EDGE_W-1:0] row_limit [4];
   logic [LEN_W-1:0]  len_reg;
   logic [2:0]        held_col;
   logic [2:0]        held_row;
   logic [KEY_W-1:0]  last_key;
   logic [3:0]        digit_q [NDIG];
   int                next_slot;

   rsp_type expected_q [$];
   stim_row_type dir_table [DIR_ROWS];

   int fail_count    = 0;
   int words_sent    = 0;
   int useful_items  = 0;
   int results_seen  = 0;
   int settings_used = 0;
   int full_seen     = 0;
   int returns_seen  = 0;
   int cycle_count   = 0;
   int stall_left    = 0;
   int hold_asked    = 0;
   int hold_done     = 0;
   bit send_idle     = 1'b1;
   bit recv_idle     = 1'b1;

   ladder_keypad_digit_entry_top #(.DIGITS(NDIG)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void blank_entry();
      for (int i = 0; i < NDIG; i++) digit_q[i] = BLANK_DIGIT;
      digit_q[NDIG-1] = 4'd0;
      next_slot = NDIG - 1;
      last_key = KEY_NONE;
   endfunction

   function automatic void predictor_reset();
      row_limit[0] = ROW1_RESET;
      row_limit[1] = ROW2_RESET;
      row_limit[2] = ROW3_RESET;
      row_limit[3] = ROW4_RESET;
      len_reg = MAX_LEN_RESET;
      held_col = 3'd0;
      held_row = 3'd0;
      blank_entry();
   endfunction

   function automatic logic [2:0] ladder_row(input logic [EDGE_W-1:0] v);
      if (v < row_limit[3]) return 3'd0;
      if (v > row_limit[0]) return 3'd1;
      if (v > row_limit[1]) return 3'd2;
      if (v > row_limit[2]) return 3'd3;
      return 3'd4;
   endfunction

   function automatic logic [KEY_W-1:0] held_char();
      if (held_col == 3'd0 || held_row == 3'd0) return KEY_NONE;
      return KEY_MAP[(int'(held_row) - 1) * 4 + int'(held_col) - 1][KEY_W-1:0];
   endfunction

   function automatic logic [KEY_W-1:0] poll_edit();
      logic [KEY_W-1:0] ck;
      int len;
      int lo;
      ck = held_char();
      len = int'(len_reg);
      if (len < 1) len = 1;
      if (len > NDIG) len = NDIG;
      lo = NDIG - len;
      if (ck == KEY_NONE) begin
         last_key = KEY_NONE;
         return KEY_NONE;
      end
      if (ck inside {[KEY_A:KEY_D], KEY_HASH}) begin
         last_key = ck;
         return ck;
      end
      if (ck == last_key) return KEY_NONE;
      last_key = ck;
      if (ck == KEY_STAR) begin
         if (next_slot >= NDIG - 2) begin
            next_slot = NDIG - 1;
            digit_q[NDIG-1] = 4'd0;
         end else begin
            for (int j = NDIG - 2; j >= lo; j--) digit_q[j+1] = digit_q[j];
            digit_q[lo] = BLANK_DIGIT;
            next_slot++;
         end
      end else if (next_slot >= 0) begin
         // leading zero is dropped
         if (ck == KEY_ZERO && next_slot == NDIG - 1) return KEY_NONE;
         if (next_slot < NDIG - 1)
            for (int j = lo + 1; j < NDIG; j++) digit_q[j-1] = digit_q[j];
         digit_q[NDIG-1] = 4'(ck - KEY_ZERO);
         next_slot--;
      end
      return KEY_NONE;
   endfunction

   function automatic rsp_type entry_predict(input req_type w);
      rsp_type r;
      logic [2:0] row;
      r = '0;
      case (w.op)
         OP_SCAN: begin
            if (w.scan_column < 3'd4) begin
               row = ladder_row(w.adc_sample);
               if (row != 3'd0) begin
                  held_col = w.scan_column + 3'd1;
                  held_row = row;
               end else if (held_col == w.scan_column + 3'd1) begin
                  held_col = 3'd0;
                  held_row = 3'd0;
               end
            end
         end
         OP_POLL: r.returned_key = poll_edit();
         OP_CLEAR: blank_entry();
         default: ;
      endcase
      r.key_code = held_char();
      for (int k = 0; k < PACK_SLOTS; k++) r.digits_packed[4*k +: 4] = digit_q[NDIG-1-k];
      r.entry_position = next_slot[3:0];
      return r;
   endfunction

   function automatic logic [EDGE_W-1:0] sample_for_row(input logic [2:0] row);
      int lo;
      int hi;
      case (row)
         3'd0: begin
            lo = 0;
            hi = int'(row_limit[3]) - 1;
         end
         3'd1: begin
            lo = int'(row_limit[0]) + 1;
            hi = 1023;
         end
         3'd2: begin
            lo = int'(row_limit[1]) + 1;
            hi = int'(row_limit[0]);
         end
         3'd3: begin
            lo = int'(row_limit[2]) + 1;
            hi = int'(row_limit[1]);
         end
         default: begin
            lo = int'(row_limit[3]);
            hi = int'(row_limit[2]);
         end
      endcase
      if (lo > hi) return 10'($urandom_range(0, 1023));
      // band edges now and then
      if ($urandom_range(0, 3) == 0) return ($urandom_range(0, 1) != 0) ? 10'(hi) : 10'(lo);
      return 10'($urandom_range(hi, lo));
   endfunction

   function automatic stim_row_type step_row(input logic [1:0] op, input logic [2:0] col,
                                             input logic [9:0] smp);
      stim_row_type s;
      s = '0;
      s.w.op = op;
      s.w.scan_column = col;
      s.w.adc_sample = smp;
      return s;
   endfunction

   function automatic stim_row_type known_row(input logic [1:0] op, input logic [2:0] col,
                                              input logic [9:0] smp, input logic [6:0] key,
                                              input logic [6:0] ret, input logic [31:0] digits,
                                              input logic signed [3:0] pos);
      stim_row_type s;
      s = step_row(op, col, smp);
      s.known = 1'b1;
      s.rsp.key_code = key;
      s.rsp.returned_key = ret;
      s.rsp.digits_packed = digits;
      s.rsp.entry_position = pos;
      return s;
   endfunction

   task automatic send_word(input req_type w, input logic known, input rsp_type known_rsp);
      int gap;
      rsp_type predicted;
      gap = send_idle ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = entry_predict(w);
      expected_q.push_back(known ? known_rsp : predicted);
      words_sent++;
      if (!(w.op == OP_UNUSED || (w.op == OP_SCAN && w.scan_column >= 3'd4))) useful_items++;
      if (next_slot == -1) full_seen++;
      if (predicted.returned_key != KEY_NONE) returns_seen++;
   endtask

   task automatic issue(input logic [1:0] op, input logic [2:0] col, input logic [9:0] smp);
      req_type w;
      w.op = op;
      w.scan_column = col;
      w.adc_sample = smp;
      send_word(w, 1'b0, '0);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_q.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_ROW1_EDGE: row_limit[0] = value;
         CSR_ROW2_EDGE: row_limit[1] = value;
         CSR_ROW3_EDGE: row_limit[2] = value;
         CSR_ROW4_EDGE: row_limit[3] = value;
         CSR_MAX_LEN: len_reg = value[LEN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [9:0] r1, input logic [9:0] r2, input logic [9:0] r3,
                            input logic [9:0] r4, input logic [3:0] len);
      write_reg(CSR_ROW1_EDGE, r1);
      write_reg(CSR_ROW2_EDGE, r2);
      write_reg(CSR_ROW3_EDGE, r3);
      write_reg(CSR_ROW4_EDGE, r4);
      write_reg(CSR_MAX_LEN, {6'd0, len});
      csr_write <= 1'b0;
      settings_used++;
   endtask

   task automatic configure_sorted(input logic [3:0] len);
      int t1;
      int t2;
      int t3;
      int t4;
      t4 = $urandom_range(0, 400);
      t3 = t4 + $urandom_range(1, 200);
      t2 = t3 + $urandom_range(1, 200);
      t1 = t2 + $urandom_range(1, 200);
      configure(10'(t1), 10'(t2), 10'(t3), 10'(t4), len);
   endtask

   // mostly press, poll, release, poll; some clears and raw noise
   task automatic run_sequence();
      int pick;
      int kidx;
      logic [2:0] col;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
         kidx = ($urandom_range(0, 9) < 7) ? DIGIT_KEYS[$urandom_range(0, 9)]
                                           : int'($urandom_range(0, 15));
         col = 3'(kidx % 4);
         issue(OP_SCAN, col, sample_for_row(3'(kidx / 4 + 1)));
         repeat ($urandom_range(1, 2))
            issue(OP_POLL, 3'($urandom_range(0, 7)), 10'($urandom_range(0, 1023)));
         if ($urandom_range(0, 3) != 0) begin
            issue(OP_SCAN, col, sample_for_row(3'd0));
            issue(OP_POLL, 3'($urandom_range(0, 7)), 10'($urandom_range(0, 1023)));
         end
      end else if (pick < 78) begin
         issue(OP_CLEAR, 3'($urandom_range(0, 7)), 10'($urandom_range(0, 1023)));
      end else begin
         issue(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), 10'($urandom_range(0, 1023)));
      end
   endtask

   initial begin : stimulus
      int target;
      predictor_reset();
      dir_table = '{
         known_row(OP_UNUSED, 3'd7, 10'd1023, KEY_NONE, KEY_NONE, 32'hffff_fff0, 4'sd7),
         known_row(OP_POLL,   3'd0, 10'd0,    KEY_NONE, KEY_NONE, 32'hffff_fff0, 4'sd7),
         known_row(OP_SCAN,   3'd0, 10'd1023, 7'h31,    KEY_NONE, 32'hffff_fff0, 4'sd7),
         known_row(OP_POLL,   3'd0, 10'd0,    7'h31,    KEY_NONE, 32'hffff_fff1, 4'sd6),
         step_row(OP_POLL, 3'd7, 10'h3ff),
         step_row(OP_SCAN, 3'd0, 10'd0),
         step_row(OP_POLL, 3'd0, 10'd0),
         step_row(OP_SCAN, 3'd1, 10'd300),
         step_row(OP_POLL, 3'd0, 10'd0),
         step_row(OP_SCAN, 3'd0, 10'd300),
         step_row(OP_POLL, 3'd0, 10'd0),
         step_row(OP_POLL, 3'd0, 10'd0),
         step_row(OP_SCAN, 3'd3, 10'd1023),
         step_row(OP_POLL, 3'd0, 10'd0),
         step_row(OP_POLL, 3'd0, 10'd0),
         step_row(OP_SCAN, 3'd3, 10'd900),
         step_row(OP_SCAN, 3'd3, 10'd700),
         step_row(OP_SCAN, 3'd3, 10'd500),
         step_row(OP_POLL, 3'd0, 10'd0),
         step_row(OP_SCAN, 3'd2, 10'd300),
         step_row(OP_POLL, 3'd0, 10'd0),
         step_row(OP_SCAN, 3'd7, 10'd0),
         known_row(OP_CLEAR,  3'd0, 10'd0,    KEY_HASH, KEY_NONE, 32'hffff_fff0, 4'sd7),
         step_row(OP_SCAN, 3'd1, 10'd300),
         step_row(OP_POLL, 3'd0, 10'd0),
         step_row(OP_SCAN, 3'd2, 10'd299),
         step_row(OP_SCAN, 3'd1, 10'd299)
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++)
         send_word(dir_table[i].w, dir_table[i].known, dir_table[i].rsp);
      drain();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: configure(ROW1_RESET, ROW2_RESET, ROW3_RESET, ROW4_RESET, MAX_LEN_RESET);
            1: configure_sorted(4'd1);
            2: configure(10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff, 4'd15);
            3: configure(10'd0, 10'd0, 10'd0, 10'd0, 4'd0);
            4: configure_sorted(4'd3);
            5: configure(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                         10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                         4'($urandom_range(0, 15)));
            6: configure_sorted(4'd8);
            default: configure_sorted(4'($urandom_range(0, 15)));
         endcase
         send_idle = (phase != 0) && ($urandom_range(0, 3) != 0);
         recv_idle = $urandom_range(0, 3) != 0;
         // back-pressure burst: sink holds off while words keep coming
         if (phase == 0) hold_asked++;
         target = useful_items + PHASE_ITEMS;
         while (useful_items < target) run_sequence();
         drain();
      end

      repeat (10) @(posedge clock);
      $display("run covered %0d words (%0d effective) over %0d register settings",
               words_sent, useful_items, settings_used);
      $display("%0d results checked, %0d words with a full entry, %0d keys handed back",
               results_seen, full_seen, returns_seen);
      if (fail_count == 0 && expected_q.size() == 0) begin
         $display("ladder_keypad_digit_entry_top_tb passed");
      end else begin
         $display("ladder_keypad_digit_entry_top_tb failed");
      end
      $finish;
   end

   // result sink stall
   always @(posedge clock) begin
      if (hold_asked != hold_done) begin
         stall_left = LONG_HOLD;
         hold_done = hold_asked;
      end else if (rsp_valid && !rsp_stall) begin
         stall_left = recv_idle ? $urandom_range(0, 15) : 0;
      end else if (stall_left > 0) begin
         stall_left--;
      end
      rsp_stall <= (stall_left != 0);
   end

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid !== 1'b0 && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual %h", $time, rsp_word);
            fail_count++;
         end else begin
            want = expected_q.pop_front();
            compare_field("key_code", want.key_code, rsp_word.key_code);
            compare_field("returned_key", want.returned_key, rsp_word.returned_key);
            compare_field("digits_packed", want.digits_packed, rsp_word.digits_packed);
            compare_field("entry_position", want.entry_position, rsp_word.entry_position);
            results_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
         $display("ladder_keypad_digit_entry_top_tb failed");
         $finish;
      end
   end

endmodule
